### hdl/gpio_command_line_parser_top_macros.svh
// Assertion macros shared by the GPIO command line parser RTL.
// Plain header: no dependencies; included by the files that assert.
`ifndef GPIO_COMMAND_LINE_PARSER_TOP_MACROS_SVH
`define GPIO_COMMAND_LINE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define GCLP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define GCLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gclp_pkg.sv
// Shared types and constants of the GPIO command line parser.
// No dependencies; used by the RTL modules and the testbench.
package gclp_pkg;

  // Characters recognized by the parser
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChQuest   = 8'h3F;
  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowCase = 8'h20;
  localparam logic [7:0] ChH       = 8'h68;
  localparam logic [7:0] ChD       = 8'h64;
  localparam logic [7:0] ChE       = 8'h65;
  localparam logic [7:0] ChG       = 8'h67;
  localparam logic [7:0] ChR       = 8'h72;
  localparam logic [7:0] ChB       = 8'h62;

  // Command codes
  localparam logic [3:0] CmdHelp      = 4'd0;
  localparam logic [3:0] CmdEchoOff   = 4'd1;
  localparam logic [3:0] CmdEchoOn    = 4'd2;
  localparam logic [3:0] CmdChangeOn  = 4'd3;
  localparam logic [3:0] CmdChangeOff = 4'd4;
  localparam logic [3:0] CmdBoot      = 4'd5;
  localparam logic [3:0] CmdHigh      = 4'd6;
  localparam logic [3:0] CmdLow       = 4'd7;
  localparam logic [3:0] CmdInput     = 4'd8;
  localparam logic [3:0] CmdOutput    = 4'd9;
  localparam logic [3:0] CmdState     = 4'd10;
  localparam logic [3:0] CmdLevel     = 4'd11;

  // Error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrInvalid = 2'd1;
  localparam logic [1:0] ErrBig     = 2'd2;
  localparam logic [1:0] ErrNoPort  = 2'd3;

  // Register map (byte address bit 2 selects the register)
  localparam int unsigned AddrWidth  = 3;
  localparam logic        RegMaxPort = 1'b0;
  localparam logic [7:0]  MaxPortRst = 8'd31;

  // Width of the decimal accumulator: 255 * 10 + 9 fits in 12 bits
  localparam int unsigned AccWidth = 12;

  // Character class, decoded from one received byte
  typedef struct packed {
    logic       is_ws;
    logic       is_eol;
    logic       is_dash;
    logic       is_prefix;
    logic [3:0] prefix_cmd;
    logic       is_letter;
    logic [3:0] letter_cmd;
    logic       is_digit;
    logic [3:0] digit;
  } char_class_t;

  // One result word
  typedef struct packed {
    logic       command_valid;
    logic [3:0] command_code;
    logic [7:0] port_number;
    logic [1:0] error_code;
  } result_t;

endpackage

### hdl/gclp_char_if.sv
// Input channel of the parser: one received character per word.
// No dependencies.
interface gclp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

### hdl/gclp_result_if.sv
// Output channel of the parser: one result word per character.
// No dependencies.
interface gclp_result_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic [3:0] command_code;
  logic [7:0] port_number;
  logic [1:0] error_code;

  modport source (output valid, output command_valid, output command_code,
                  output port_number, output error_code, input ready);
  modport sink   (input valid, input command_valid, input command_code,
                  input port_number, input error_code, output ready);
endinterface

### hdl/gpio_command_line_parser_top.sv
// Top level of the GPIO command line parser: APB register, input register,
// character decoder and parser. Depends on gclp_pkg, the two channel
// interfaces, gclp_apb_regs, gclp_char_class and gclp_parser.

// Parses console lines one character per word. Each accepted character
// gives exactly one result word, in order: a completed command (code and
// port), an error (invalid character, port above max_port, missing port
// number) or an empty word. Space and tab are skipped; a lone CR or LF is
// skipped; any error drops the line and restarts at the prefix.
// Throughput: one character per cycle, sustained, whenever the result side
// takes a word each cycle. A character goes through the input register and
// then the result register. The per-character cost is the parser step:
// decode, accumulator times ten plus digit, and the compare against
// max_port, all combinational. While a finished word waits on the result
// side, the input register takes at most one more word and then holds off
// the input. max_port sits at byte address 0 of the APB port (reset 31);
// it is to be written only while idle; the block itself does not enforce this.
module gpio_command_line_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gclp_char_if.sink                      char_i,
  gclp_result_if.source                  result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gclp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic                  in_valid_q;
  logic [7:0]            char_q;
  logic                  step;
  logic                  res_free;
  logic [7:0]            max_port;
  gclp_pkg::char_class_t cls;
  gclp_pkg::result_t     res;

  gclp_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_port_o (max_port)
  );

  // Input register: refills in the cycle its word moves on to the parser
  assign step         = in_valid_q && res_free;
  assign char_i.ready = !in_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      char_q <= char_i.char_in;
    end
  end

  gclp_char_class u_class (
    .char_i (char_q),
    .cls_o  (cls)
  );

  gclp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cls_i       (cls),
    .max_port_i  (max_port),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .free_o      (res_free),
    .res_o       (res)
  );

  assign result_o.command_valid = res.command_valid;
  assign result_o.command_code  = res.command_code;
  assign result_o.port_number   = res.port_number;
  assign result_o.error_code    = res.error_code;

endmodule

### hdl/gclp_apb_regs.sv
// APB configuration register file of the parser (max_port).
// Depends on gclp_pkg.
module gclp_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gclp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [7:0]                    max_port_o
);

  logic [7:0] max_port_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == gclp_pkg::RegMaxPort);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_port_q <= gclp_pkg::MaxPortRst;
    end else if (wr_en) begin
      max_port_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == gclp_pkg::RegMaxPort) begin
      prdata = {24'd0, max_port_q};
    end
  end

  assign max_port_o = max_port_q;

endmodule

### hdl/gclp_char_class.sv
// Character decoder: sorts one byte into the classes the parser acts on.
// Depends on gclp_pkg; purely combinational.
module gclp_char_class (
  input  logic [7:0]            char_i,
  output gclp_pkg::char_class_t cls_o
);

  logic [7:0] folded;

  // Setting bit 5 maps upper-case letters onto lower case
  assign folded = char_i | gclp_pkg::ChLowCase;

  always_comb begin
    cls_o            = '0;
    cls_o.is_ws      = (char_i == gclp_pkg::ChSpace) || (char_i == gclp_pkg::ChTab);
    cls_o.is_eol     = (char_i == gclp_pkg::ChCr) || (char_i == gclp_pkg::ChLf);
    cls_o.is_dash    = (char_i == gclp_pkg::ChDash);
    cls_o.is_digit   = (char_i >= gclp_pkg::ChZero) && (char_i <= gclp_pkg::ChNine);
    cls_o.digit      = char_i[3:0];

    cls_o.is_prefix  = 1'b1;
    case (char_i)
      gclp_pkg::ChCaret:   cls_o.prefix_cmd = gclp_pkg::CmdHigh;
      gclp_pkg::ChUnder:   cls_o.prefix_cmd = gclp_pkg::CmdLow;
      gclp_pkg::ChPercent: cls_o.prefix_cmd = gclp_pkg::CmdInput;
      gclp_pkg::ChAmp:     cls_o.prefix_cmd = gclp_pkg::CmdOutput;
      gclp_pkg::ChQuest:   cls_o.prefix_cmd = gclp_pkg::CmdState;
      gclp_pkg::ChAt:      cls_o.prefix_cmd = gclp_pkg::CmdLevel;
      default: begin
        cls_o.is_prefix  = 1'b0;
        cls_o.prefix_cmd = gclp_pkg::CmdHelp;
      end
    endcase

    cls_o.is_letter  = 1'b1;
    case (folded)
      gclp_pkg::ChH: cls_o.letter_cmd = gclp_pkg::CmdHelp;
      gclp_pkg::ChD: cls_o.letter_cmd = gclp_pkg::CmdEchoOff;
      gclp_pkg::ChE: cls_o.letter_cmd = gclp_pkg::CmdEchoOn;
      gclp_pkg::ChG: cls_o.letter_cmd = gclp_pkg::CmdChangeOn;
      gclp_pkg::ChR: cls_o.letter_cmd = gclp_pkg::CmdChangeOff;
      gclp_pkg::ChB: cls_o.letter_cmd = gclp_pkg::CmdBoot;
      default: begin
        cls_o.is_letter  = 1'b0;
        cls_o.letter_cmd = gclp_pkg::CmdHelp;
      end
    endcase
  end

endmodule

### hdl/gclp_parser.sv
// Line parser state machine with the result register.
// Depends on gclp_pkg and gpio_command_line_parser_top_macros.svh.
`include "gpio_command_line_parser_top_macros.svh"

module gclp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  gclp_pkg::char_class_t cls_i,
  input  logic [7:0]            max_port_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  free_o,
  output gclp_pkg::result_t     res_o
);

  typedef enum logic [1:0] {
    PhPrefix,
    PhLetter,
    PhNumber,
    PhDelim
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [3:0]                      cmd_q, cmd_d;
  logic [gclp_pkg::AccWidth-1:0]   acc_q, acc_d;
  logic                            seen_q, seen_d;
  logic                            res_valid_q;
  gclp_pkg::result_t               res_q, res_d;
  logic [gclp_pkg::AccWidth-1:0]   acc_next;

  // acc * 10 + digit as two shifted adds
  assign acc_next = {acc_q[gclp_pkg::AccWidth-4:0], 3'b000}
                  + {acc_q[gclp_pkg::AccWidth-2:0], 1'b0}
                  + {{(gclp_pkg::AccWidth-4){1'b0}}, cls_i.digit};

  assign free_o = !res_valid_q || out_ready_i;

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    res_d   = '0;
    if (!cls_i.is_ws) begin
      case (phase_q)
        PhPrefix: begin
          cmd_d = gclp_pkg::CmdHelp;
          if (cls_i.is_eol) begin
            phase_d = PhPrefix;
          end else if (cls_i.is_dash) begin
            phase_d = PhLetter;
          end else if (cls_i.is_prefix) begin
            cmd_d   = cls_i.prefix_cmd;
            acc_d   = '0;
            seen_d  = 1'b0;
            phase_d = PhNumber;
          end else begin
            res_d.error_code = gclp_pkg::ErrInvalid;
          end
        end
        PhLetter: begin
          if (cls_i.is_letter) begin
            cmd_d   = cls_i.letter_cmd;
            phase_d = PhDelim;
          end else begin
            res_d.error_code = gclp_pkg::ErrInvalid;
            phase_d          = PhPrefix;
          end
        end
        PhNumber: begin
          if (cls_i.is_digit) begin
            acc_d  = acc_next;
            seen_d = 1'b1;
            if (acc_next > {{(gclp_pkg::AccWidth-8){1'b0}}, max_port_i}) begin
              res_d.error_code = gclp_pkg::ErrBig;
              phase_d          = PhPrefix;
            end
          end else if (cls_i.is_eol) begin
            phase_d = PhPrefix;
            if (!seen_q) begin
              res_d.error_code = gclp_pkg::ErrNoPort;
            end else begin
              res_d.command_valid = 1'b1;
              res_d.command_code  = cmd_q;
              res_d.port_number   = acc_q[7:0];
            end
          end else begin
            res_d.error_code = gclp_pkg::ErrInvalid;
            phase_d          = PhPrefix;
          end
        end
        PhDelim: begin
          phase_d = PhPrefix;
          if (cls_i.is_eol) begin
            res_d.command_valid = 1'b1;
            res_d.command_code  = cmd_q;
          end else begin
            res_d.error_code = gclp_pkg::ErrInvalid;
          end
        end
        default: begin
          phase_d = PhPrefix;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhPrefix;
      cmd_q       <= '0;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        acc_q   <= acc_d;
        seen_q  <= seen_d;
      end
      if (free_o) begin
        res_valid_q <= step_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign res_o       = res_q;

  `GCLP_ASSERT_NOW(a_step_has_room, clk_i, rst_ni, step_i, free_o,
    "parser stepped while the result register was blocked")
  `GCLP_ASSERT_NOW(a_cmd_no_error, clk_i, rst_ni, res_valid_q && res_q.command_valid,
    (res_q.error_code == gclp_pkg::ErrNone) && (res_q.command_code <= gclp_pkg::CmdLevel),
    "completed command carries an error or a bad code")
  `GCLP_ASSERT_NOW(a_empty_fields, clk_i, rst_ni, res_valid_q && !res_q.command_valid,
    (res_q.command_code == gclp_pkg::CmdHelp) && (res_q.port_number == 8'd0),
    "result without a command has nonzero fields")
  `GCLP_ASSERT_NEXT(a_error_resets, clk_i, rst_ni,
    step_i && (res_d.error_code != gclp_pkg::ErrNone), phase_q == PhPrefix,
    "parser did not return to the prefix phase after an error")

endmodule

### dv/tb_gpio_command_line_parser_top.sv
// Self-checking testbench of gpio_command_line_parser_top: a character driver, a result
// monitor with its own line parser, and APB writes of max_port between phases.
// Depends on gclp_pkg, gclp_char_if, gclp_result_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_gpio_command_line_parser_top;
  import gclp_pkg::*;

  // Parser phases of the prediction, same order as the block walks them
  typedef enum logic [1:0] {PhPrefix, PhLetter, PhNumber, PhEol} parse_phase_e;

  localparam int unsigned IdleLimit   = 2000;  // cycles with no word moving
  localparam int unsigned LongStall   = 300;   // one long hold-off on the result side
  localparam int unsigned StallAfter  = 320;   // chars accepted before that hold-off
  localparam int unsigned PhaseChars  = 185;   // random chars per configuration

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  gclp_char_if   char_if ();
  gclp_result_if res_if ();

  gpio_command_line_parser_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shared bookkeeping. The monitor owns chars_accepted, the driver owns
  // chars_offered; the initial block fills chars_pending.
  logic [7:0]  chars_pending[$];
  result_t     results_due[$];
  int unsigned chars_offered;
  int unsigned chars_accepted;
  int unsigned fail_count;
  int unsigned gap_left;
  int unsigned stall_left;
  logic        long_stall_done;
  logic        quiet_tail;

  // Predicted parser state and register copy
  parse_phase_e        ph_q;
  logic [3:0]          cmd_q;
  logic [AccWidth-1:0] acc_q;
  logic                digit_seen_q;
  logic [7:0]          max_port_q;

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction: one result word per character, state updated in place.
  // --------------------------------------------------------------------------
  function automatic result_t parse_char(input logic [7:0] c);
    result_t    r;
    logic       eol;
    logic [7:0] lc;
    r   = '0;
    eol = (c == ChCr) || (c == ChLf);
    lc  = c | ChLowCase;
    // whitespace is transparent in every phase
    if (c == ChSpace || c == ChTab) return r;
    case (ph_q)
      PhPrefix: begin
        cmd_q = CmdHelp;
        if (eol) begin
          // empty line, nothing to report
        end else if (c == ChDash) begin
          ph_q = PhLetter;
        end else begin
          case (c)
            ChCaret:   cmd_q = CmdHigh;
            ChUnder:   cmd_q = CmdLow;
            ChPercent: cmd_q = CmdInput;
            ChAmp:     cmd_q = CmdOutput;
            ChQuest:   cmd_q = CmdState;
            ChAt:      cmd_q = CmdLevel;
            default:   r.error_code = ErrInvalid;
          endcase
          if (r.error_code == ErrNone) begin
            acc_q        = '0;
            digit_seen_q = 1'b0;
            ph_q         = PhNumber;
          end
        end
      end
      PhLetter: begin
        // letters match in either case; bytes above 0x7f never match
        case (lc)
          ChH:     cmd_q = CmdHelp;
          ChD:     cmd_q = CmdEchoOff;
          ChE:     cmd_q = CmdEchoOn;
          ChG:     cmd_q = CmdChangeOn;
          ChR:     cmd_q = CmdChangeOff;
          ChB:     cmd_q = CmdBoot;
          default: r.error_code = ErrInvalid;
        endcase
        if (r.error_code == ErrNone) ph_q = PhEol;
      end
      PhNumber: begin
        if (c >= ChZero && c <= ChNine) begin
          acc_q        = acc_q * 12'd10 + AccWidth'(c - ChZero);
          digit_seen_q = 1'b1;
          // range check after every digit, not only at end of line
          if (acc_q > {4'b0, max_port_q}) r.error_code = ErrBig;
        end else if (eol) begin
          if (!digit_seen_q) begin
            r.error_code = ErrNoPort;
          end else begin
            r.command_valid = 1'b1;
            r.command_code  = cmd_q;
            r.port_number   = acc_q[7:0];
            ph_q            = PhPrefix;
          end
        end else begin
          r.error_code = ErrInvalid;
        end
      end
      default: begin
        if (eol) begin
          r.command_valid = 1'b1;
          r.command_code  = cmd_q;
          ph_q            = PhPrefix;
        end else begin
          r.error_code = ErrInvalid;
        end
      end
    endcase
    // any error drops the line
    if (r.error_code != ErrNone) ph_q = PhPrefix;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: checks result words, then records accepted chars. Both handshakes
  // are seen in one process so the order of queue updates is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (results_due.size() == 0) begin
          $error("result word with no character waiting for it");
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("command_valid", 8'(want.command_valid), 8'(res_if.command_valid));
          check_field("command_code", 8'(want.command_code), 8'(res_if.command_code));
          check_field("port_number", want.port_number, res_if.port_number);
          check_field("error_code", 8'(want.error_code), 8'(res_if.error_code));
        end
      end
      if (char_if.valid && char_if.ready) begin
        results_due.push_back(parse_char(char_if.char_in));
        chars_accepted++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers chars from the pending queue at the falling edge, with
  // random gaps between words. valid gets one NBA per step.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    logic next_valid;
    if (rst_ni) begin
      next_valid = char_if.valid;
      // free when nothing is offered or the offered word went in
      if (!char_if.valid || chars_accepted == chars_offered) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (chars_pending.size() > 0) begin
          if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 14);
          end else begin
            char_if.char_in <= chars_pending.pop_front();
            next_valid = 1'b1;
            chars_offered++;
          end
        end
      end
      char_if.valid <= next_valid;
    end
  end

  // Result side: short random stalls, plus one long hold-off while the driver
  // keeps offering, so the block backs up into its input.
  always @(negedge clk_i) begin : sink
    if (rst_ni) begin
      if (!long_stall_done && chars_accepted >= StallAfter) begin
        stall_left      = LongStall;
        long_stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 14);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any long stretch with no word moving on either side is a hang
  always @(posedge clk_i) begin : watchdog
    int unsigned idle_cycles;
    if (!rst_ni || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c);
    chars_pending.push_back(c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic maybe_ws();
    if ($urandom_range(0, 7) == 0) push_char($urandom_range(0, 1) ? ChSpace : ChTab);
  endtask

  task automatic push_eol();
    case ($urandom_range(0, 2))
      0: push_char(ChCr);
      1: push_char(ChLf);
      default: begin
        // CRLF: the LF lands in the prefix phase as an empty line
        push_char(ChCr);
        push_char(ChLf);
      end
    endcase
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] l;
    case ($urandom_range(0, 5))
      0: l = ChH;
      1: l = ChD;
      2: l = ChE;
      3: l = ChG;
      4: l = ChR;
      default: l = ChB;
    endcase
    // upper case half the time
    return $urandom_range(0, 1) ? (l & ~ChLowCase) : l;
  endfunction

  function automatic logic [7:0] pick_prefix();
    case ($urandom_range(0, 5))
      0: return ChCaret;
      1: return ChUnder;
      2: return ChPercent;
      3: return ChAmp;
      4: return ChQuest;
      default: return ChAt;
    endcase
  endfunction

  // Decimal port, mostly in range of the current max_port, some above it,
  // a few four-digit ones; leading zeros now and then.
  task automatic push_number();
    int unsigned v;
    int unsigned pick;
    string       s;
    pick = $urandom_range(0, 99);
    if (pick < 60)      v = $urandom_range(0, max_port_q);
    else if (pick < 85) v = $urandom_range(0, 255);
    else                v = $urandom_range(0, 2559);
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) push_char(ChZero);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i]);
      maybe_ws();
    end
  endtask

  // One random line: mostly well formed, the rest broken lines and noise
  task automatic gen_line();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    maybe_ws();
    if (kind < 32) begin
      push_char(pick_prefix());
      maybe_ws();
      push_number();
      push_eol();
    end else if (kind < 54) begin
      push_char(ChDash);
      maybe_ws();
      push_char(pick_letter());
      maybe_ws();
      push_eol();
    end else if (kind < 60) begin
      // prefix with no number
      push_char(pick_prefix());
      maybe_ws();
      push_eol();
    end else if (kind < 76) begin
      case ($urandom_range(0, 5))
        0: begin
          push_char(ChDash);
          push_char(ChZero + 8'($urandom_range(0, 9)));
        end
        1: push_char(ChDash);
        2: begin
          push_char(ChDash);
          push_char(8'($urandom_range(0, 255)));
        end
        3: begin
          push_char(pick_prefix());
          push_char(8'($urandom_range(0, 255)));
        end
        4: begin
          push_char(ChDash);
          push_char(pick_letter());
          push_char(pick_letter());
        end
        default: begin
          push_char(pick_prefix());
          push_number();
          push_char(8'($urandom_range(0, 255)));
        end
      endcase
      push_eol();
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
    end else begin
      push_eol();
    end
  endtask

  task automatic write_max_port(input logic [7:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {RegMaxPort, 2'b00};
    pwdata  = {24'b0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    max_port_q = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Every char given gives a word, so empty queues mean the block is idle;
  // the wait then also covers the input and result registers.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (chars_pending.size() != 0 || chars_offered != chars_accepted ||
           results_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] max_port, input logic last);
    int unsigned target;
    write_max_port(max_port);
    @(posedge clk_i);
    quiet_tail = last;
    target = chars_pending.size() + PhaseChars;
    while (chars_pending.size() < target) gen_line();
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: directed chars at the reset max_port, then random phases over
  // several max_port settings (both extremes), the last one with no idling.
  // --------------------------------------------------------------------------
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    char_if.valid   = 1'b0;
    char_if.char_in = '0;
    res_if.ready    = 1'b0;
    chars_offered   = 0;
    chars_accepted  = 0;
    fail_count      = 0;
    gap_left        = 0;
    stall_left      = 0;
    long_stall_done = 1'b0;
    quiet_tail      = 1'b0;
    ph_q            = PhPrefix;
    cmd_q           = CmdHelp;
    acc_q           = '0;
    digit_seen_q    = 1'b0;
    max_port_q      = MaxPortRst;

    // whitespace, then empty lines on CR and on LF
    push_char(ChSpace);
    push_char(ChTab);
    push_char(ChCr);
    push_char(ChLf);
    // help, then upper-case letter with a space before LF
    push_text("-h");
    push_char(ChCr);
    push_text("-D ");
    push_char(ChLf);
    // largest port allowed, then one above it (error on the second digit)
    push_text("^31");
    push_char(ChCr);
    push_text("@32");
    push_char(ChLf);
    // prefix with no number
    push_char(ChQuest);
    push_char(ChCr);
    // digit after dash, end of line after dash, byte extremes
    push_text("-5-");
    push_char(ChLf);
    push_char(8'hFF);
    push_char(8'h00);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait_idle();

    run_phase(8'd255, 1'b0);
    run_phase(8'd0, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 1'b0);
    run_phase(8'd9, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 1'b1);

    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
